/* rtl/core/pds_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the PLL divider search block.
package pds_pkg;

	// Field widths
	localparam int unsigned FREQ_W = 27;
	localparam int unsigned TOL_W  = 23;
	localparam int unsigned FAC_W  = 4;
	localparam int unsigned N_W    = 7;
	localparam int unsigned VIN_W  = 24;
	localparam int unsigned WIN_W  = 28;
	localparam int unsigned VCO_W  = 31;
	localparam int unsigned FOUT_W = 30;

	// Register map (index is paddr[2])
	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_TOL    = 1'b1;

	localparam logic [FREQ_W-1:0] TARGET_RESET = 27'd48000000;
	localparam logic [TOL_W-1:0]  TOL_RESET    = 23'd1920000;

	// Search limits
	localparam logic [FREQ_W-1:0] VIN_LOW   = 27'd4000000;
	localparam logic [FREQ_W-1:0] VIN_HIGH  = 27'd16000000;
	localparam logic [VCO_W-1:0]  VCO_LOW   = 31'd64000000;
	localparam logic [VCO_W-1:0]  VCO_HIGH  = 31'd344000000;
	localparam logic [FOUT_W-1:0] FOUT_STOP = 30'd80000000;
	localparam logic [FAC_W-1:0]  M_FIRST   = 4'd1;
	localparam logic [FAC_W-1:0]  M_LAST    = 4'd8;
	localparam logic [FAC_W-1:0]  R_FIRST   = 4'd2;
	localparam logic [FAC_W-1:0]  R_LAST    = 4'd8;
	localparam logic [FAC_W-1:0]  R_STEP    = 4'd2;
	localparam logic [N_W-1:0]    N_FIRST   = 7'd8;
	localparam logic [N_W-1:0]    N_LAST    = 7'd86;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] dividend;
		logic [FAC_W-1:0]  divisor;
	} pds_div_req_t;

	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] quot;
		logic [FAC_W-1:0]  rem;
	} pds_div_rsp_t;

endpackage

/* rtl/core/pds_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider: 27-bit dividend by a small divisor, one bit a cycle.
module pds_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pds_pkg::pds_div_req_t req,
	output pds_pkg::pds_div_rsp_t rsp
);
	import pds_pkg::*;

	localparam int unsigned CNT_W = $clog2(FREQ_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FREQ_W-1:0] num_q;
	logic [FAC_W-1:0]  rem_q;
	logic [FAC_W-1:0]  den_q;
	logic [FAC_W:0]    trial;
	logic [FAC_W:0]    diff;
	logic              ge;

	// One restoring step
	always_comb begin
		trial = {rem_q, num_q[FREQ_W-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			// done pulses for one cycle after the last step
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FREQ_W - 1);
				num_q  <= req.dividend;
				den_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[FREQ_W-2:0], ge};
				rem_q <= ge ? diff[FAC_W-1:0] : trial[FAC_W-1:0];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/core/pds_regs.sv */
`timescale 1ns / 1ps
// APB register file: target frequency and tolerance.
module pds_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [pds_pkg::FREQ_W-1:0]  tgt_hz,
	output logic [pds_pkg::TOL_W-1:0]   freq_tolerance
);
	import pds_pkg::*;

	logic              wr_en;
	logic [FREQ_W-1:0] target_q;
	logic [TOL_W-1:0]  tol_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			tol_q    <= TOL_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TARGET: begin
					target_q <= pwdata[FREQ_W-1:0];
				end
				REG_TOL: begin
					tol_q <= pwdata[TOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[2])
			REG_TARGET: prdata = {{(32-FREQ_W){1'b0}}, target_q};
			REG_TOL:    prdata = {{(32-TOL_W){1'b0}}, tol_q};
			default:    prdata = '0;
		endcase
	end

	assign tgt_hz         = target_q;
	assign freq_tolerance = tol_q;

endmodule

/* rtl/core/pds_seq.sv */
`timescale 1ns / 1ps
// Search sequencer: M/R/N loops, incremental N stepper and result register.
module pds_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [pds_pkg::FREQ_W-1:0]  source_freq,
	input  logic [pds_pkg::FREQ_W-1:0]  tgt_hz,
	input  logic [pds_pkg::TOL_W-1:0]   freq_tolerance,
	output pds_pkg::pds_div_req_t       div_req,
	input  pds_pkg::pds_div_rsp_t       div_rsp,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        found,
	output logic [pds_pkg::FAC_W-1:0]   div_m,
	output logic [pds_pkg::N_W-1:0]     mul_n,
	output logic [pds_pkg::FAC_W-1:0]   div_r,
	output logic                        exact_match
);
	import pds_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MDIV = 5'b00010,
		ST_RDIV = 5'b00100,
		ST_NRUN = 5'b01000,
		ST_DONE = 5'b10000
	} pds_state_t;

	pds_state_t        state_q;
	pds_div_req_t      div_req_q;
	logic [FREQ_W-1:0] src_q;
	logic              pass_q;
	logic [FAC_W-1:0]  m_q;
	logic [FAC_W-1:0]  r_q;
	logic [N_W-1:0]    n_q;
	logic [VIN_W-1:0]  vin_q;
	logic [VIN_W-1:0]  qa_q;
	logic [FAC_W-1:0]  ra_q;
	logic [VCO_W-1:0]  vco_q;
	logic [FOUT_W-1:0] fout_q;
	logic [FAC_W-1:0]  frac_q;
	logic [WIN_W-1:0]  lo_q;
	logic [WIN_W-1:0]  hi_q;

	// Pending result and output register
	logic              res_found_q;
	logic [FAC_W-1:0]  res_m_q;
	logic [N_W-1:0]    res_n_q;
	logic [FAC_W-1:0]  res_r_q;
	logic              res_exact_q;
	logic              rsp_valid_q;
	logic              found_q;
	logic [FAC_W-1:0]  div_m_q;
	logic [N_W-1:0]    mul_n_q;
	logic [FAC_W-1:0]  div_r_q;
	logic              exact_q;

	logic              vin_ok;
	logic              vco_ok;
	logic              in_win;
	logic              over_stop;
	logic              hit;
	logic              end_r;
	logic              end_m;
	logic              end_pass;
	logic [FAC_W:0]    frac_sum;
	logic              carry;
	logic [FAC_W-1:0]  frac_nx;
	logic [FOUT_W-1:0] fout_nx;
	logic [VCO_W-1:0]  vco_nx;
	logic [WIN_W-1:0]  tol_ext;
	logic [WIN_W-1:0]  tgt_ext;
	logic [WIN_W-1:0]  lo_calc;
	logic [WIN_W-1:0]  hi_calc;

	// Tolerance window for the second pass, lower edge clamped at zero
	always_comb begin
		tol_ext = {{(WIN_W-TOL_W){1'b0}}, freq_tolerance};
		tgt_ext = {{(WIN_W-FREQ_W){1'b0}}, tgt_hz};
		lo_calc = (tgt_ext >= tol_ext) ? (tgt_ext - tol_ext) : '0;
		hi_calc = tgt_ext + tol_ext;
	end

	// Candidate checks on the current N
	always_comb begin
		vin_ok    = (div_rsp.quot >= VIN_LOW) && (div_rsp.quot <= VIN_HIGH);
		vco_ok    = (vco_q >= VCO_LOW) && (vco_q <= VCO_HIGH);
		in_win    = (fout_q >= {{(FOUT_W-WIN_W){1'b0}}, lo_q}) &&
		            (fout_q <= {{(FOUT_W-WIN_W){1'b0}}, hi_q});
		over_stop = (fout_q > FOUT_STOP);
	end

	// Next N: vco += vin, fout tracked as quotient and remainder by r
	always_comb begin
		vco_nx   = vco_q + {{(VCO_W-VIN_W){1'b0}}, vin_q};
		frac_sum = {1'b0, frac_q} + {1'b0, ra_q};
		carry    = (frac_sum >= {1'b0, r_q});
		frac_nx  = carry ? FAC_W'(frac_sum - {1'b0, r_q}) : frac_sum[FAC_W-1:0];
		fout_nx  = fout_q + {{(FOUT_W-VIN_W){1'b0}}, qa_q} + {{(FOUT_W-1){1'b0}}, carry};
	end

	// Loop ends
	always_comb begin
		hit   = 1'b0;
		end_r = 1'b0;
		end_m = 1'b0;
		unique case (state_q)
			ST_MDIV: begin
				end_m = div_rsp.done && !vin_ok;
			end
			ST_NRUN: begin
				if (n_q >= N_FIRST) begin
					if (vco_ok && in_win) begin
						hit = 1'b1;
					end else if (vco_ok && over_stop) begin
						end_r = 1'b1;
					end else if (n_q == N_LAST) begin
						end_r = 1'b1;
					end
				end
				end_m = end_r && (r_q == R_LAST);
			end
			default: begin
			end
		endcase
		end_pass = end_m && (m_q == M_LAST);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_req_q   <= '0;
			src_q       <= '0;
			pass_q      <= 1'b0;
			m_q         <= '0;
			r_q         <= '0;
			n_q         <= '0;
			vin_q       <= '0;
			qa_q        <= '0;
			ra_q        <= '0;
			vco_q       <= '0;
			fout_q      <= '0;
			frac_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			res_found_q <= 1'b0;
			res_m_q     <= '0;
			res_n_q     <= '0;
			res_r_q     <= '0;
			res_exact_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			div_m_q     <= '0;
			mul_n_q     <= '0;
			div_r_q     <= '0;
			exact_q     <= 1'b0;
		end else begin
			// divider start is a one-cycle pulse
			if (div_req_q.start) begin
				div_req_q.start <= 1'b0;
			end
			// output beat taken; ST_DONE reloads the register itself
			if (rsp_valid_q && rsp_ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						src_q     <= source_freq;
						pass_q    <= 1'b0;
						lo_q      <= tgt_ext;
						hi_q      <= tgt_ext;
						m_q       <= M_FIRST;
						div_req_q <= '{start: 1'b1, dividend: source_freq, divisor: M_FIRST};
						state_q   <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_rsp.done && vin_ok) begin
						vin_q     <= div_rsp.quot[VIN_W-1:0];
						r_q       <= R_FIRST;
						div_req_q <= '{start: 1'b1, dividend: div_rsp.quot, divisor: R_FIRST};
						state_q   <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_rsp.done) begin
						qa_q    <= div_rsp.quot[VIN_W-1:0];
						ra_q    <= div_rsp.rem;
						n_q     <= '0;
						vco_q   <= '0;
						fout_q  <= '0;
						frac_q  <= '0;
						state_q <= ST_NRUN;
					end
				end
				ST_NRUN: begin
					if (hit) begin
						res_found_q <= 1'b1;
						res_m_q     <= m_q;
						res_n_q     <= n_q;
						res_r_q     <= r_q;
						res_exact_q <= !pass_q;
						state_q     <= ST_DONE;
					end else if (end_r) begin
						if (r_q != R_LAST) begin
							r_q       <= r_q + R_STEP;
							div_req_q <= '{start: 1'b1,
							               dividend: {{(FREQ_W-VIN_W){1'b0}}, vin_q},
							               divisor: r_q + R_STEP};
							state_q   <= ST_RDIV;
						end
					end else begin
						n_q    <= n_q + 1'b1;
						vco_q  <= vco_nx;
						fout_q <= fout_nx;
						frac_q <= frac_nx;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						found_q     <= res_found_q;
						div_m_q     <= res_m_q;
						mul_n_q     <= res_n_q;
						div_r_q     <= res_r_q;
						exact_q     <= res_exact_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Next M, or end of a pass
			if (end_pass) begin
				if (!pass_q) begin
					pass_q    <= 1'b1;
					lo_q      <= lo_calc;
					hi_q      <= hi_calc;
					m_q       <= M_FIRST;
					div_req_q <= '{start: 1'b1, dividend: src_q, divisor: M_FIRST};
					state_q   <= ST_MDIV;
				end else begin
					res_found_q <= 1'b0;
					res_m_q     <= '0;
					res_n_q     <= '0;
					res_r_q     <= '0;
					res_exact_q <= 1'b0;
					state_q     <= ST_DONE;
				end
			end else if (end_m) begin
				m_q       <= m_q + 1'b1;
				div_req_q <= '{start: 1'b1, dividend: src_q, divisor: m_q + 1'b1};
				state_q   <= ST_MDIV;
			end
		end
	end

	assign req_ready   = (state_q == ST_IDLE);
	assign div_req     = div_req_q;
	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign div_m       = div_m_q;
	assign mul_n       = mul_n_q;
	assign div_r       = div_r_q;
	assign exact_match = exact_q;

endmodule

/* rtl/core/pll_divider_search_core.sv */
`timescale 1ns / 1ps
// Top level of the PLL divider search block.
//
// Send a source oscillator frequency on the req channel (req_valid/req_ready,
// source_freq in Hz). One beat comes back on the rsp channel with found,
// div_m, mul_n, div_r and exact_match. Target frequency and tolerance sit in
// an APB register file (target at 0x0, tolerance at 0x4); write them only
// while no search is running.
// An item takes one zero-tolerance pass and, when that misses, a second pass
// with the tolerance. Each M runs one division in the shared divider; each
// valid M adds, per R, one more division plus one step per N from 0 up to
// where the N loop stops (at most 87).
// req_ready is high only while the block is idle. The result sits in an
// output register; the next item is taken while it waits, and a finished
// search holds until that register is free when rsp_ready stays low.
// Reset clears the sequencer and output valid, and loads the register
// defaults (48 MHz target, 1.92 MHz tolerance).
module pll_divider_search_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [pds_pkg::FREQ_W-1:0]  source_freq,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        found,
	output logic [pds_pkg::FAC_W-1:0]   div_m,
	output logic [pds_pkg::N_W-1:0]     mul_n,
	output logic [pds_pkg::FAC_W-1:0]   div_r,
	output logic                        exact_match
);
	import pds_pkg::*;

	logic [FREQ_W-1:0] tgt_hz;
	logic [TOL_W-1:0]  freq_tolerance;
	pds_div_req_t      div_req;
	pds_div_rsp_t      div_rsp;

	// Configuration registers
	pds_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.tgt_hz         (tgt_hz),
		.freq_tolerance (freq_tolerance)
	);

	// Shared divider for src/M and vin/R
	pds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Search sequencer
	pds_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.source_freq    (source_freq),
		.tgt_hz         (tgt_hz),
		.freq_tolerance (freq_tolerance),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.found          (found),
		.div_m          (div_m),
		.mul_n          (mul_n),
		.div_r          (div_r),
		.exact_match    (exact_match)
	);

endmodule
